@@ hw/rtl/cbl_pkg.sv @@
// ----------------------------------------------------------------------------
// Clipped transparent blitter package
// Shared widths, codes, reset values and structures of the blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbl_pkg;

  localparam int COORD_BITS  = 11;
  localparam int ADDR_BITS   = 20;
  localparam int CFG_BITS    = 10;
  localparam int PIX_BITS    = 8;
  localparam int KIND_BITS   = 3;
  localparam int WORK_BITS   = COORD_BITS + 2;
  localparam int ORG_BITS    = COORD_BITS + 1;
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 32;
  localparam int REG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_BITS-1:0] DST_W_RESET = CFG_BITS'(320);
  localparam logic [CFG_BITS-1:0] DST_H_RESET = CFG_BITS'(200);
  localparam logic [CFG_BITS-1:0] SRC_W_RESET = CFG_BITS'(320);
  localparam logic [CFG_BITS-1:0] SRC_H_RESET = CFG_BITS'(200);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NONE  = 3'd0,
    KIND_START = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_SKIP  = 3'd3,
    KIND_IDLE  = 3'd4
  } kind_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_DST_W = 2'd0,
    REG_DST_H = 2'd1,
    REG_SRC_W = 2'd2,
    REG_SRC_H = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    IT_EMPTY = 2'd0,
    IT_START = 2'd1,
    IT_PIXEL = 2'd2
  } item_class_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] dst_w;
    logic [CFG_BITS-1:0] dst_h;
    logic [CFG_BITS-1:0] src_w;
    logic [CFG_BITS-1:0] src_h;
  } cfg_t;

  typedef struct packed {
    item_class_t          cls;
    logic                 keyed;
    logic                 pix_zero;
    logic [CFG_BITS-1:0]  span_w;
    logic [CFG_BITS-1:0]  span_h;
    logic [CFG_BITS-1:0]  org_dx;
    logic [CFG_BITS-1:0]  org_dy;
    logic [ORG_BITS-1:0]  org_sx;
    logic [ORG_BITS-1:0]  org_sy;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [ADDR_BITS-1:0] src_addr;
  } fe_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/cbl_if.sv @@
// ----------------------------------------------------------------------------
// Blitter stream interfaces
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbl_in_if import cbl_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] dst_x;
  logic signed [COORD_BITS-1:0] dst_y;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic signed [COORD_BITS-1:0] rect_w;
  logic signed [COORD_BITS-1:0] rect_h;
  logic                         whole_source;
  logic                         color_key;
  logic [PIX_BITS-1:0]          pixel;

  modport source (
    output valid, action, dst_x, dst_y, rect_x, rect_y, rect_w, rect_h,
           whole_source, color_key, pixel,
    input  ready
  );
  modport sink (
    input  valid, action, dst_x, dst_y, rect_x, rect_y, rect_w, rect_h,
           whole_source, color_key, pixel,
    output ready
  );
endinterface

interface cbl_out_if import cbl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic                 write_enable;
  logic [ADDR_BITS-1:0] dst_addr;
  logic [ADDR_BITS-1:0] src_addr;
  logic [CFG_BITS-1:0]  clip_w;
  logic [CFG_BITS-1:0]  clip_h;
  logic                 last;

  modport source (
    output valid, kind, write_enable, dst_addr, src_addr, clip_w, clip_h, last,
    input  ready
  );
  modport sink (
    input  valid, kind, write_enable, dst_addr, src_addr, clip_w, clip_h, last,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/cbl_regs.sv @@
// ----------------------------------------------------------------------------
// Blitter register file
// APB-style access to the destination and source buffer dimensions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbl_regs import cbl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DST_W: cfg_nxt.dst_w = pwdata[CFG_BITS-1:0];
        REG_DST_H: cfg_nxt.dst_h = pwdata[CFG_BITS-1:0];
        REG_SRC_W: cfg_nxt.src_w = pwdata[CFG_BITS-1:0];
        REG_SRC_H: cfg_nxt.src_h = pwdata[CFG_BITS-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DST_W: prdata = PDATA_BITS'(cfg_r.dst_w);
      REG_DST_H: prdata = PDATA_BITS'(cfg_r.dst_h);
      REG_SRC_W: prdata = PDATA_BITS'(cfg_r.src_w);
      REG_SRC_H: prdata = PDATA_BITS'(cfg_r.src_h);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dst_w <= DST_W_RESET;
      cfg_r.dst_h <= DST_H_RESET;
      cfg_r.src_w <= SRC_W_RESET;
      cfg_r.src_h <= SRC_H_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cbl_front.sv @@
// ----------------------------------------------------------------------------
// Blitter front end
// Takes command beats, normalizes the rectangle and clips its near edges in
// a first stage, then forms starting addresses and classifies in a second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbl_front import cbl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cbl_in_if.sink     in_ch,
  input  cfg_t       cfg,
  output fe_item_t   item,
  output logic       item_valid,
  input  wire logic  item_ready
);

  typedef struct packed {
    logic                        is_pixel;
    logic                        keyed;
    logic                        pix_zero;
    logic                        far;
    logic signed [WORK_BITS-1:0] dx;
    logic signed [WORK_BITS-1:0] dy;
    logic signed [WORK_BITS-1:0] sx;
    logic signed [WORK_BITS-1:0] sy;
    logic signed [WORK_BITS-1:0] sw;
    logic signed [WORK_BITS-1:0] sh;
  } fe_stage_t;

  logic                        s1_v_r;
  fe_stage_t                   s1_r;
  fe_stage_t                   s1_nxt;
  logic                        s2_v_r;
  fe_item_t                    s2_r;
  fe_item_t                    s2_nxt;
  logic                        s1_adv;
  logic                        s2_adv;

  logic signed [WORK_BITS-1:0] dw;
  logic signed [WORK_BITS-1:0] dh;
  logic signed [WORK_BITS-1:0] a_dx, a_dy, a_sx, a_sy, a_sw, a_sh;
  logic signed [WORK_BITS-1:0] b_dx, b_dy, b_sw, b_sh, b_sw2, b_sh2;
  logic signed [ORG_BITS-1:0]  b_sx_o, b_sy_o;
  logic [ADDR_BITS-1:0]        b_sx_a, b_sy_a, b_dx_a, b_dy_a;
  logic                        b_empty;

  assign dw = $signed(WORK_BITS'(cfg.dst_w));
  assign dh = $signed(WORK_BITS'(cfg.dst_h));

  assign s2_adv       = !s2_v_r || item_ready;
  assign s1_adv       = !s1_v_r || s2_adv;
  assign in_ch.ready  = s1_adv;
  assign item_valid   = s2_v_r;
  assign item         = s2_r;

  // Normalize a negative size and move a negative destination corner to zero.
  always_comb begin
    a_dx = WORK_BITS'(in_ch.dst_x);
    a_dy = WORK_BITS'(in_ch.dst_y);
    if (in_ch.whole_source) begin
      a_sx = '0;
      a_sy = '0;
      a_sw = $signed(WORK_BITS'(cfg.src_w));
      a_sh = $signed(WORK_BITS'(cfg.src_h));
    end else begin
      a_sx = WORK_BITS'(in_ch.rect_x);
      a_sy = WORK_BITS'(in_ch.rect_y);
      a_sw = WORK_BITS'(in_ch.rect_w);
      a_sh = WORK_BITS'(in_ch.rect_h);
    end
    s1_nxt.far = (a_dx > dw) || (a_dy > dh);
    if (a_sw < 0) begin
      a_sx = a_sx + a_sw;
      a_sw = -a_sw;
    end
    if (a_sh < 0) begin
      a_sy = a_sy + a_sh;
      a_sh = -a_sh;
    end
    if (a_dx < 0) begin
      a_sx = a_sx - a_dx;
      a_sw = a_sw + a_dx;
      a_dx = '0;
    end
    if (a_dy < 0) begin
      a_sy = a_sy - a_dy;
      a_sh = a_sh + a_dy;
      a_dy = '0;
    end
    s1_nxt.is_pixel = in_ch.action;
    s1_nxt.keyed    = in_ch.color_key;
    s1_nxt.pix_zero = (in_ch.pixel == '0);
    s1_nxt.dx       = a_dx;
    s1_nxt.dy       = a_dy;
    s1_nxt.sx       = a_sx;
    s1_nxt.sy       = a_sy;
    s1_nxt.sw       = a_sw;
    s1_nxt.sh       = a_sh;
  end

  // Clip against the far edges and form the first pixel's addresses.
  always_comb begin
    b_dx    = s1_r.dx;
    b_dy    = s1_r.dy;
    b_sw    = s1_r.sw;
    b_sh    = s1_r.sh;
    b_sw2   = (b_dx + b_sw > dw) ? (dw - b_dx) : b_sw;
    b_sh2   = (b_dy + b_sh > dh) ? (dh - b_dy) : b_sh;
    b_empty = s1_r.far || (b_sw2 <= 0) || (b_sh2 <= 0);
    b_sx_o  = s1_r.sx[ORG_BITS-1:0];
    b_sy_o  = s1_r.sy[ORG_BITS-1:0];
    b_sx_a  = ADDR_BITS'(b_sx_o);
    b_sy_a  = ADDR_BITS'(b_sy_o);
    b_dx_a  = ADDR_BITS'(b_dx[CFG_BITS-1:0]);
    b_dy_a  = ADDR_BITS'(b_dy[CFG_BITS-1:0]);

    if (s1_r.is_pixel) begin
      s2_nxt.cls = IT_PIXEL;
    end else if (b_empty) begin
      s2_nxt.cls = IT_EMPTY;
    end else begin
      s2_nxt.cls = IT_START;
    end
    s2_nxt.keyed    = s1_r.keyed;
    s2_nxt.pix_zero = s1_r.pix_zero;
    s2_nxt.span_w   = b_sw2[CFG_BITS-1:0];
    s2_nxt.span_h   = b_sh2[CFG_BITS-1:0];
    s2_nxt.org_dx   = b_dx[CFG_BITS-1:0];
    s2_nxt.org_dy   = b_dy[CFG_BITS-1:0];
    s2_nxt.org_sx   = b_sx_o;
    s2_nxt.org_sy   = b_sy_o;
    s2_nxt.dst_addr = b_dy_a * ADDR_BITS'(cfg.dst_w) + b_dx_a;
    s2_nxt.src_addr = b_sy_a * ADDR_BITS'(cfg.src_w) + b_sx_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_r <= s1_nxt;
    end
    if (s2_adv) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cbl_queue.sv @@
// ----------------------------------------------------------------------------
// Blitter command queue
// Short FIFO between the front end and the pixel engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbl_queue import cbl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  fe_item_t  push_item,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output fe_item_t  pop_item
);

  fe_item_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;
  logic                   push;
  logic                   pop;

  assign push_ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cbl_back.sv @@
// ----------------------------------------------------------------------------
// Blitter pixel engine
// Holds the blit state, steps the row and column counters, forms each
// pixel's destination and source addresses from the blit origin and the
// current pitches, and registers one result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbl_back import cbl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  input  wire logic  head_valid,
  output logic       head_ready,
  input  fe_item_t   head,
  cbl_out_if.source  out_ch
);

  typedef struct packed {
    kind_t                kind;
    logic                 we;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [ADDR_BITS-1:0] src_addr;
    logic [CFG_BITS-1:0]  clip_w;
    logic [CFG_BITS-1:0]  clip_h;
    logic                 last;
  } res_t;

  logic                 busy_r,     busy_nxt;
  logic                 keyed_r,    keyed_nxt;
  logic [CFG_BITS-1:0]  col_r,      col_nxt;
  logic [CFG_BITS-1:0]  row_r,      row_nxt;
  logic [CFG_BITS-1:0]  span_w_r,   span_w_nxt;
  logic [CFG_BITS-1:0]  span_h_r,   span_h_nxt;
  logic [CFG_BITS-1:0]  org_dx_r,   org_dx_nxt;
  logic [CFG_BITS-1:0]  org_dy_r,   org_dy_nxt;
  logic [ORG_BITS-1:0]  org_sx_r,   org_sx_nxt;
  logic [ORG_BITS-1:0]  org_sy_r,   org_sy_nxt;
  logic                 out_v_r;
  res_t                 res_r,      res_nxt;

  logic                 take;
  logic [CFG_BITS:0]    col_inc;
  logic [CFG_BITS:0]    row_inc;
  logic                 row_end;
  logic                 blit_end;
  logic [ADDR_BITS-1:0] sx_ext;
  logic [ADDR_BITS-1:0] dst_y;
  logic [ADDR_BITS-1:0] src_y;
  logic [ADDR_BITS-1:0] dst_pix;
  logic [ADDR_BITS-1:0] src_base;
  logic [ADDR_BITS-1:0] src_same;
  logic [ADDR_BITS-1:0] src_down;
  logic                 pix_we;

  assign head_ready = !out_v_r || out_ch.ready;
  assign take       = head_valid && head_ready;

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign row_end  = (col_inc >= {1'b0, span_w_r});
  assign blit_end = row_end && (row_inc >= {1'b0, span_h_r});

  // Addresses use the pitches as they are now, so a new pitch applies at once.
  assign sx_ext   = {{(ADDR_BITS-ORG_BITS){org_sx_r[ORG_BITS-1]}}, org_sx_r};
  assign dst_y    = ADDR_BITS'(org_dy_r) + ADDR_BITS'(row_r);
  assign src_y    = {{(ADDR_BITS-ORG_BITS){org_sy_r[ORG_BITS-1]}}, org_sy_r} +
                    ADDR_BITS'(row_r);
  assign dst_pix  = dst_y * ADDR_BITS'(cfg.dst_w) + ADDR_BITS'(org_dx_r) +
                    ADDR_BITS'(col_r);
  assign src_base = src_y * ADDR_BITS'(cfg.src_w) + sx_ext;
  assign src_same = src_base + ADDR_BITS'(col_inc);
  assign src_down = src_base + ADDR_BITS'(cfg.src_w);
  assign pix_we   = !(keyed_r && head.pix_zero);

  always_comb begin
    busy_nxt    = busy_r;
    keyed_nxt   = keyed_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    span_w_nxt  = span_w_r;
    span_h_nxt  = span_h_r;
    org_dx_nxt  = org_dx_r;
    org_dy_nxt  = org_dy_r;
    org_sx_nxt  = org_sx_r;
    org_sy_nxt  = org_sy_r;
    res_nxt     = '0;
    unique case (head.cls)
      IT_EMPTY: begin
        busy_nxt     = 1'b0;
        res_nxt.kind = KIND_NONE;
      end
      IT_START: begin
        busy_nxt         = 1'b1;
        keyed_nxt        = head.keyed;
        col_nxt          = '0;
        row_nxt          = '0;
        span_w_nxt       = head.span_w;
        span_h_nxt       = head.span_h;
        org_dx_nxt       = head.org_dx;
        org_dy_nxt       = head.org_dy;
        org_sx_nxt       = head.org_sx;
        org_sy_nxt       = head.org_sy;
        res_nxt.kind     = KIND_START;
        res_nxt.dst_addr = head.dst_addr;
        res_nxt.src_addr = head.src_addr;
        res_nxt.clip_w   = head.span_w;
        res_nxt.clip_h   = head.span_h;
      end
      IT_PIXEL: begin
        if (!busy_r) begin
          res_nxt.kind = KIND_IDLE;
        end else begin
          res_nxt.kind     = pix_we ? KIND_WRITE : KIND_SKIP;
          res_nxt.we       = pix_we;
          res_nxt.dst_addr = dst_pix;
          if (blit_end) begin
            col_nxt      = '0;
            row_nxt      = '0;
            busy_nxt     = 1'b0;
            res_nxt.last = 1'b1;
          end else if (row_end) begin
            col_nxt          = '0;
            row_nxt          = row_inc[CFG_BITS-1:0];
            res_nxt.src_addr = src_down;
          end else begin
            col_nxt          = col_inc[CFG_BITS-1:0];
            res_nxt.src_addr = src_same;
          end
        end
      end
      default: begin
        res_nxt.kind = KIND_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      keyed_r  <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      span_w_r <= '0;
      span_h_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (take) begin
        busy_r   <= busy_nxt;
        keyed_r  <= keyed_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        span_w_r <= span_w_nxt;
        span_h_r <= span_h_nxt;
        out_v_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      org_dx_r <= org_dx_nxt;
      org_dy_r <= org_dy_nxt;
      org_sx_r <= org_sx_nxt;
      org_sy_r <= org_sy_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = res_r.kind;
  assign out_ch.write_enable = res_r.we;
  assign out_ch.dst_addr     = res_r.dst_addr;
  assign out_ch.src_addr     = res_r.src_addr;
  assign out_ch.clip_w       = res_r.clip_w;
  assign out_ch.clip_h       = res_r.clip_h;
  assign out_ch.last         = res_r.last;

endmodule

`default_nettype wire

@@ hw/rtl/clipped_transparent_blitter.sv @@
// ----------------------------------------------------------------------------
// Clipped transparent blitter
// Every beat on in_ch yields exactly one result beat on out_ch, one beat per
// clock sustained while out_ch is ready. A start beat is normalized and its
// near edges clipped in the first front stage; its far edges are clipped and
// its first destination and source addresses formed by one multiply each in
// the second. The pixel engine forms each pixel's addresses from the blit
// origin, its row and column counters and the current pitches, so a pitch
// written during a blit applies from the next pixel on. A two-beat queue lets
// the front end keep taking beats while a result waits for ready. The user
// must write registers over the APB-style port only while no beat is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clipped_transparent_blitter import cbl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cbl_in_if.sink                     in_ch,
  cbl_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready
);

  cfg_t     cfg;
  fe_item_t fe_item;
  logic     fe_valid;
  logic     fe_ready;
  fe_item_t q_item;
  logic     q_valid;
  logic     q_ready;

  cbl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .item       (fe_item),
    .item_valid (fe_valid),
    .item_ready (fe_ready)
  );

  cbl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_item  (fe_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  cbl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (q_valid),
    .head_ready (q_ready),
    .head       (q_item),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cbl_checker.sv @@
// ----------------------------------------------------------------------------
// Blitter port checker
// Assertions on the result channel of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbl_checker import cbl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [KIND_BITS-1:0] out_kind,
  input wire logic                 out_write_enable,
  input wire logic [ADDR_BITS-1:0] out_dst_addr,
  input wire logic [ADDR_BITS-1:0] out_src_addr,
  input wire logic [CFG_BITS-1:0]  out_clip_w,
  input wire logic [CFG_BITS-1:0]  out_clip_h,
  input wire logic                 out_last
);

  logic [3:0] pend_r;
  logic       in_beat;
  logic       out_beat;
  logic       is_pix;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign is_pix   = (out_kind == KIND_WRITE) || (out_kind == KIND_SKIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_beat && !out_beat) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_dst_addr) && $stable(out_src_addr) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NONE) |-> !out_write_enable &&
      (out_dst_addr == '0) && (out_src_addr == '0) && (out_clip_w == '0) &&
      (out_clip_h == '0) && !out_last)
    else $error("nothing-to-draw result carries data");

  a_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_pix |-> (out_write_enable == (out_kind == KIND_WRITE)) &&
      (out_clip_w == '0) && (out_clip_h == '0))
    else $error("pixel result has inconsistent enable or size");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> is_pix && (out_src_addr == '0))
    else $error("final pixel result is malformed");

  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result beat without an accepted command beat");

endmodule

bind clipped_transparent_blitter cbl_checker u_cbl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_write_enable (out_ch.write_enable),
  .out_dst_addr     (out_ch.dst_addr),
  .out_src_addr     (out_ch.src_addr),
  .out_clip_w       (out_ch.clip_w),
  .out_clip_h       (out_ch.clip_h),
  .out_last         (out_ch.last)
);

`default_nettype wire
